>>> hdl/fpd_pkg.sv
`default_nettype none

package fpd_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_REF_FREQ     = 3'd0;
   localparam logic [2:0] REG_PRESCALE_THR = 3'd1;
   localparam logic [2:0] REG_LOW_BOTTOM   = 3'd2;
   localparam logic [2:0] REG_LOW_TOP      = 3'd3;
   localparam logic [2:0] REG_MID_BOTTOM   = 3'd4;
   localparam logic [2:0] REG_MID_TOP      = 3'd5;
   localparam logic [2:0] REG_HIGH_BOTTOM  = 3'd6;
   localparam logic [2:0] REG_HIGH_TOP     = 3'd7;

   // Register reset values in hertz.
   localparam logic [26:0] RESET_REF_FREQ     = 27'd30720000;
   localparam logic [32:0] RESET_PRESCALE_THR = 33'd5500000000;
   localparam logic [32:0] RESET_LOW_BOTTOM   = 33'd3600000000;
   localparam logic [32:0] RESET_LOW_TOP      = 33'd5000000000;
   localparam logic [32:0] RESET_MID_BOTTOM   = 33'd4800000000;
   localparam logic [32:0] RESET_MID_TOP      = 33'd6600000000;
   localparam logic [32:0] RESET_HIGH_BOTTOM  = 33'd6300000000;
   localparam logic [32:0] RESET_HIGH_TOP     = 33'd7700000000;

   // VCO select values as they appear in the result.
   localparam logic [1:0] VCO_LOW  = 2'd0;
   localparam logic [1:0] VCO_MID  = 2'd1;
   localparam logic [1:0] VCO_HIGH = 2'd2;

   localparam int NUM_DIV  = 7;
   localparam int NUM_BAND = 3;

   // Output dividers in search order 128, 64, 32, 16, 8, 4, 2 as shift counts.
   localparam logic [2:0] DIV_SHIFT [NUM_DIV] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
   localparam logic [2:0] DIV_CODE  [NUM_DIV] = '{3'd6, 3'd5, 3'd3, 3'd2, 3'd4, 3'd1, 3'd0};

   // Settings that ride along with a request through the ratio divider.
   typedef struct packed {
      logic [1:0]  vsel;
      logic [2:0]  code;
      logic        pre;
      logic [32:0] fvco;
      logic [2:0]  shift;
      logic [27:0] den;
      logic        zero;
      logic        low;
      logic        high;
   } side_type;

endpackage

`default_nettype wire

>>> hdl/fractional_pll_divider_planner.sv
// Stages from request to result: A, B, C, D, the ratio divider stages, M and O.
// Throughput: one request per cycle; every stage moves whenever the stage after it is
// empty or moving, so a stalled result only holds the stages that are full behind it.
// The ratio divider retires four quotient bits per stage and sets the pipeline depth.
// Reset (synchronous, active high) empties the pipeline and loads the default band plan.
`default_nettype none

module fractional_pll_divider_planner #(
   parameter int FRAC_BITS = 20,
   localparam int QW     = FRAC_BITS + 11,
   localparam int PW     = 28 + QW,
   localparam int RSP_W  = ((81 + FRAC_BITS + 7) / 8) * 8
) (
   input  wire               clock,
   input  wire               reset,
   // Request channel.
   input  wire               req_tvalid,
   output logic              req_tready,
   input  wire  [31:0]       req_tdata,   // desired_freq_hz[31:0]
   // Result channel.
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // int_ratio[9:0], frac_ratio, vco_select[1:0],
                                          // divider_code[2:0], prescaler_on, vco_freq_hz[32:0],
                                          // actual_freq_hz[31:0], zero fill
   // Configuration write port.
   input  wire               csr_we,
   input  wire  [2:0]        csr_index,
   input  wire  [32:0]       csr_wdata
);

   // ---------------------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------------------
   logic [26:0] ref_ff;
   logic [32:0] thr_ff, lbb_ff, lbt_ff, mbb_ff, mbt_ff, hbb_ff, hbt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= fpd_pkg::RESET_REF_FREQ;
         thr_ff <= fpd_pkg::RESET_PRESCALE_THR;
         lbb_ff <= fpd_pkg::RESET_LOW_BOTTOM;
         lbt_ff <= fpd_pkg::RESET_LOW_TOP;
         mbb_ff <= fpd_pkg::RESET_MID_BOTTOM;
         mbt_ff <= fpd_pkg::RESET_MID_TOP;
         hbb_ff <= fpd_pkg::RESET_HIGH_BOTTOM;
         hbt_ff <= fpd_pkg::RESET_HIGH_TOP;
      end else if (csr_we) begin
         case (csr_index)
            fpd_pkg::REG_REF_FREQ:     ref_ff <= csr_wdata[26:0];
            fpd_pkg::REG_PRESCALE_THR: thr_ff <= csr_wdata;
            fpd_pkg::REG_LOW_BOTTOM:   lbb_ff <= csr_wdata;
            fpd_pkg::REG_LOW_TOP:      lbt_ff <= csr_wdata;
            fpd_pkg::REG_MID_BOTTOM:   mbb_ff <= csr_wdata;
            fpd_pkg::REG_MID_TOP:      mbt_ff <= csr_wdata;
            fpd_pkg::REG_HIGH_BOTTOM:  hbb_ff <= csr_wdata;
            fpd_pkg::REG_HIGH_TOP:     hbt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Flow control. Each stage loads when it is empty or its contents move on.
   // ---------------------------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, m_valid_ff, o_valid_ff;
   logic en_a, en_b, en_c, en_d, en_m, en_o;
   logic div_in_ready, div_out_valid;

   assign en_o       = ~o_valid_ff | rsp_tready;
   assign en_m       = ~m_valid_ff | en_o;
   assign en_d       = ~d_valid_ff | div_in_ready;
   assign en_c       = ~c_valid_ff | en_d;
   assign en_b       = ~b_valid_ff | en_c;
   assign en_a       = ~a_valid_ff | en_b;
   assign req_tready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= req_tvalid;
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
         if (en_m) m_valid_ff <= div_out_valid;
         if (en_o) o_valid_ff <= m_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage A: clamp the request to [ceil(low bottom / 128), floor(high top / 2)].
   // The upper limit is tested first, so it wins when the two limits cross.
   // ---------------------------------------------------------------------------------------
   logic [31:0] a_f_ff, a_f_in;
   logic [33:0] lbb_round;

   always_comb begin
      lbb_round = {1'b0, lbb_ff} + 34'd127;
      if ({req_tdata, 1'b0} > hbt_ff) begin
         a_f_in = hbt_ff[32:1];
      end else if ({req_tdata, 7'b0} < {6'b0, lbb_ff}) begin
         a_f_in = 32'(lbb_round >> 7);
      end else begin
         a_f_in = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req_tvalid) a_f_ff <= a_f_in;
   end

   // ---------------------------------------------------------------------------------------
   // Stage B: window search. All 21 band and divider windows are compared in parallel and
   // the first hit in the order high, middle, low band and divider 128 down to 2 is taken.
   // The high band with divider 2 also accepts the exact band top, so the overall maximum
   // is reachable. When no window holds the frequency the low band with divider 2 is used.
   // ---------------------------------------------------------------------------------------
   logic [31:0] b_f_ff;
   logic [2:0]  b_shift_ff, b_shift_in;
   logic [2:0]  b_code_ff, b_code_in;
   logic [1:0]  b_vsel_ff, b_vsel_in;

   always_comb begin
      logic [32:0] bot [fpd_pkg::NUM_BAND];
      logic [32:0] top [fpd_pkg::NUM_BAND];
      logic [38:0] v;
      logic        below;
      logic        found;
      bot[0] = hbb_ff;  top[0] = hbt_ff;
      bot[1] = mbb_ff;  top[1] = mbt_ff;
      bot[2] = lbb_ff;  top[2] = lbt_ff;
      found      = 1'b0;
      b_shift_in = fpd_pkg::DIV_SHIFT[fpd_pkg::NUM_DIV-1];
      b_code_in  = fpd_pkg::DIV_CODE[fpd_pkg::NUM_DIV-1];
      b_vsel_in  = fpd_pkg::VCO_LOW;
      for (int b = 0; b < fpd_pkg::NUM_BAND; b++) begin
         for (int d = 0; d < fpd_pkg::NUM_DIV; d++) begin
            v     = {7'b0, a_f_ff} << fpd_pkg::DIV_SHIFT[d];
            below = (v < {6'b0, top[b]}) ||
                    ((b == 0) && (d == fpd_pkg::NUM_DIV - 1) && (v == {6'b0, top[b]}));
            if (!found && (v >= {6'b0, bot[b]}) && below) begin
               found      = 1'b1;
               b_shift_in = fpd_pkg::DIV_SHIFT[d];
               b_code_in  = fpd_pkg::DIV_CODE[d];
               b_vsel_in  = fpd_pkg::VCO_HIGH - 2'(b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && a_valid_ff) begin
         b_f_ff     <= a_f_ff;
         b_shift_ff <= b_shift_in;
         b_code_ff  <= b_code_in;
         b_vsel_ff  <= b_vsel_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage C: VCO frequency, prescaler decision and the ratio denominator.
   // The VCO frequency always fits 33 bits: a found window bounds it by the band top, else the stage A clamp does.
   // ---------------------------------------------------------------------------------------
   fpd_pkg::side_type c_side_ff, c_side_in;
   logic [38:0]       c_fvco_wide;

   always_comb begin
      c_fvco_wide     = {7'b0, b_f_ff} << b_shift_ff;
      c_side_in       = '0;
      c_side_in.vsel  = b_vsel_ff;
      c_side_in.code  = b_code_ff;
      c_side_in.shift = b_shift_ff;
      c_side_in.fvco  = c_fvco_wide[32:0];
      c_side_in.pre   = c_fvco_wide[32:0] > thr_ff;
      c_side_in.den   = c_side_in.pre ? {ref_ff, 1'b0} : {1'b0, ref_ff};
   end

   always_ff @(posedge clock) begin
      if (en_c && b_valid_ff) c_side_ff <= c_side_in;
   end

   // ---------------------------------------------------------------------------------------
   // Stage D: range flags for the ratio: zero reference, ratio below 4, ratio of 1028 or more.
   // ---------------------------------------------------------------------------------------
   fpd_pkg::side_type d_side_ff, d_side_in;
   logic [37:0]       d_limit;

   always_comb begin
      d_limit        = ({10'b0, c_side_ff.den} << 10) + ({10'b0, c_side_ff.den} << 2);
      d_side_in      = c_side_ff;
      d_side_in.zero = (c_side_ff.den == 28'd0);
      d_side_in.low  = {5'b0, c_side_ff.fvco} < {8'b0, c_side_ff.den, 2'b0};
      d_side_in.high = {5'b0, c_side_ff.fvco} >= d_limit;
   end

   always_ff @(posedge clock) begin
      if (en_d && c_valid_ff) d_side_ff <= d_side_in;
   end

   // ---------------------------------------------------------------------------------------
   // Ratio divider: integer and fractional feedback ratio in one quotient.
   // ---------------------------------------------------------------------------------------
   fpd_pkg::side_type div_side;
   logic [QW-1:0]     div_quot;

   fpd_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .in_ready  (div_in_ready),
      .in_side   (d_side_ff),
      .out_valid (div_out_valid),
      .out_ready (en_m),
      .out_side  (div_side),
      .out_quot  (div_quot)
   );

   // ---------------------------------------------------------------------------------------
   // Stage M: saturate the ratio and multiply it back by the denominator.
   // ---------------------------------------------------------------------------------------
   fpd_pkg::side_type     m_side_ff;
   logic [9:0]            m_nint_ff, m_nint_in;
   logic [FRAC_BITS-1:0]  m_nfrac_ff, m_nfrac_in;
   logic [PW-1:0]         m_prod_ff, m_prod_in;
   logic [QW-1:0]         m_ratio;

   always_comb begin
      if (div_side.low) begin
         m_nint_in  = '0;
         m_nfrac_in = '0;
      end else if (div_side.high) begin
         m_nint_in  = '1;
         m_nfrac_in = '1;
      end else begin
         m_nint_in  = 10'(div_quot[QW-1:FRAC_BITS] - 11'd4);
         m_nfrac_in = div_quot[FRAC_BITS-1:0];
      end
      m_ratio   = {({1'b0, m_nint_in} + 11'd4), m_nfrac_in};
      m_prod_in = PW'(div_side.den) * PW'(m_ratio);
   end

   always_ff @(posedge clock) begin
      if (en_m && div_out_valid) begin
         m_side_ff  <= div_side;
         m_nint_ff  <= m_nint_in;
         m_nfrac_ff <= m_nfrac_in;
         m_prod_ff  <= m_prod_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage O: scale down by the divider and 2^FRAC_BITS, saturate, zero ratio and frequency on zero ref, hold result.
   // ---------------------------------------------------------------------------------------
   logic [9:0]            o_nint_ff, o_nint_in;
   logic [FRAC_BITS-1:0]  o_nfrac_ff, o_nfrac_in;
   logic [1:0]            o_vsel_ff;
   logic [2:0]            o_code_ff;
   logic                  o_pre_ff;
   logic [32:0]           o_fvco_ff;
   logic [31:0]           o_actual_ff, o_actual_in;
   logic [PW-1:0]         o_scaled;

   always_comb begin
      o_scaled = (m_prod_ff >> FRAC_BITS) >> m_side_ff.shift;
      if (m_side_ff.zero) begin
         o_nint_in   = '0;
         o_nfrac_in  = '0;
         o_actual_in = '0;
      end else begin
         o_nint_in   = m_nint_ff;
         o_nfrac_in  = m_nfrac_ff;
         o_actual_in = (|o_scaled[PW-1:32]) ? '1 : o_scaled[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_o && m_valid_ff) begin
         o_nint_ff   <= o_nint_in;
         o_nfrac_ff  <= o_nfrac_in;
         o_vsel_ff   <= m_side_ff.vsel;
         o_code_ff   <= m_side_ff.code;
         o_pre_ff    <= m_side_ff.pre;
         o_fvco_ff   <= m_side_ff.fvco;
         o_actual_ff <= o_actual_in;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RSP_W'({o_actual_ff, o_fvco_ff, o_pre_ff, o_code_ff, o_vsel_ff,
                               o_nfrac_ff, o_nint_ff});

   // ---------------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------------
   a_ready_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> a_valid_ff)
      else $error("request refused while the clamp stage is empty");

   a_vsel_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (o_vsel_ff <= fpd_pkg::VCO_HIGH))
      else $error("VCO select out of range");

   a_prescaler: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (o_pre_ff == (o_fvco_ff > thr_ff)))
      else $error("prescaler decision does not match VCO frequency");

   a_zero_ref: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (ref_ff == 27'd0)) |-> ((o_actual_ff == 32'd0) && (o_nint_ff == 10'd0)))
      else $error("zero reference must give zero ratio and frequency");

   a_result_flow: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && !rsp_tvalid) |=> rsp_tvalid)
      else $error("result lost between multiply and output stages");

endmodule

`default_nettype wire

>>> hdl/fpd_divider.sv
`default_nettype none

// Pipelined restoring divider: floor(fvco * 2^FRAC_BITS / den), four quotient bits
// per stage. The quotient is valid when fvco < 2048 * den.
module fpd_divider #(
   parameter int FRAC_BITS = 20,
   localparam int QW = FRAC_BITS + 11
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  fpd_pkg::side_type   in_side,
   output logic                out_valid,
   input  wire                 out_ready,
   output fpd_pkg::side_type   out_side,
   output logic [QW-1:0]       out_quot
);

   localparam int STEPS = 4;
   localparam int NST   = (QW + STEPS - 1) / STEPS;
   localparam int QP    = NST * STEPS;
   localparam int LW    = QP - FRAC_BITS;

   logic                valid_ff [NST];
   logic [27:0]         rem_ff   [NST];
   logic [QP-1:0]       low_ff   [NST];
   logic [QP-1:0]       quot_ff  [NST];
   fpd_pkg::side_type   side_ff  [NST];

   logic                src_valid [NST];
   logic [27:0]         src_rem   [NST];
   logic [QP-1:0]       src_low   [NST];
   logic [QP-1:0]       src_quot  [NST];
   fpd_pkg::side_type   src_side  [NST];

   logic [27:0]         rem_in  [NST];
   logic [QP-1:0]       low_in  [NST];
   logic [QP-1:0]       quot_in [NST];
   logic                en      [NST+1];

   assign en[NST]  = out_ready;
   assign in_ready = en[0];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      assign en[s] = ~valid_ff[s] | en[s+1];

      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_rem[s]   = 28'(in_side.fvco >> LW);
         assign src_low[s]   = QP'(in_side.fvco) << FRAC_BITS;
         assign src_quot[s]  = '0;
         assign src_side[s]  = in_side;
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_low[s]   = low_ff[s-1];
         assign src_quot[s]  = quot_ff[s-1];
         assign src_side[s]  = side_ff[s-1];
      end

      always_comb begin
         logic [28:0]   t;
         logic [27:0]   r;
         logic [QP-1:0] l;
         logic [QP-1:0] q;
         r = src_rem[s];
         l = src_low[s];
         q = src_quot[s];
         for (int i = 0; i < STEPS; i++) begin
            t = {r, l[QP-1]};
            l = l << 1;
            if (t >= {1'b0, src_side[s].den}) begin
               t = t - {1'b0, src_side[s].den};
               q = {q[QP-2:0], 1'b1};
            end else begin
               q = {q[QP-2:0], 1'b0};
            end
            r = t[27:0];
         end
         rem_in[s]  = r;
         low_in[s]  = l;
         quot_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en[s]) begin
            valid_ff[s] <= src_valid[s];
         end
         if (en[s] && src_valid[s]) begin
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            quot_ff[s] <= quot_in[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_side  = side_ff[NST-1];
   assign out_quot  = quot_ff[NST-1][QW-1:0];

endmodule

`default_nettype wire
